@@ rtl/core/fpe_pkg.sv @@
package fpe_pkg;

    // Width of the argument and of each result field.
    localparam int DATA_W = 8;
    // Result tdata carries prime and exponent side by side.
    localparam int OUT_DATA_W = 2 * DATA_W;
    // Default largest argument covered by the prime flag store.
    localparam int MAX_N_DEF = 255;
    // Smallest argument that has any prime factor in its factorial.
    localparam logic [DATA_W-1:0] FIRST_PRIME = DATA_W'(2);

    // Read request into the prime flag store.
    typedef struct packed {
        logic              en;
        logic [DATA_W-1:0] addr;
    } fpe_rd_req_t;

    // Start of one serial division.
    typedef struct packed {
        logic              start;
        logic [DATA_W-1:0] dividend;
        logic [DATA_W-1:0] divisor;
    } fpe_div_req_t;

    // Completion of one serial division.
    typedef struct packed {
        logic              done;
        logic [DATA_W-1:0] quotient;
    } fpe_div_res_t;

endpackage

@@ rtl/core/factorial_prime_exponents.sv @@
// Timing: a result for n below two passes through ST_EMIT into the output register; otherwise the
// first result follows the flag reads of the candidates scanned and the serial divisions.
// Throughput: one argument at a time; the flag reads, the Legendre terms in the serial divider
// and the emission of each prime all come before the next argument is taken.
// Reset: synchronous, active low; the sieve then fills the flag store, reads the flag of each
// base and strikes out the multiples of each prime base, with s_tready low throughout.
module factorial_prime_exponents import fpe_pkg::*; #(
    parameter int MAX_N = MAX_N_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [DATA_W-1:0]     s_tdata,   // [7:0] n
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [OUT_DATA_W-1:0] m_tdata,   // [7:0] prime, [15:8] exponent
    output logic                  m_tlast,
    output logic                  m_tuser    // [0] empty_res
);

    // The controller walks the candidates from 2 up to n, reading one prime
    // flag per candidate. For each prime it forms the Legendre sum by dividing
    // the running quotient by p again and again in the serial divider, until
    // the quotient falls below p. A finished result is held back until the
    // next prime is found or the scan reaches n, which tells whether it closes
    // the run.
    typedef enum logic [2:0] {
        ST_SIEVE,
        ST_IDLE,
        ST_READ,
        ST_CHECK,
        ST_DIV,
        ST_DIV_WAIT,
        ST_EMIT
    } state_t;

    state_t                  state_reg, state_next;
    logic [DATA_W-1:0]       n_reg, n_next;
    logic [DATA_W-1:0]       p_reg, p_next;
    logic [DATA_W-1:0]       q_reg, q_next;
    logic [DATA_W-1:0]       sum_reg, sum_next;
    logic [DATA_W-1:0]       pend_prime_reg, pend_prime_next;
    logic [DATA_W-1:0]       pend_exp_reg, pend_exp_next;
    logic                    pend_last_reg, pend_last_next;
    logic                    pend_empty_reg, pend_empty_next;
    logic                    have_pend_reg, have_pend_next;
    logic                    m_tvalid_reg, m_tvalid_next;
    logic [OUT_DATA_W-1:0]   m_tdata_reg, m_tdata_next;
    logic                    m_tlast_reg, m_tlast_next;
    logic                    m_tuser_reg, m_tuser_next;

    fpe_rd_req_t             rd_req;
    logic                    rd_flag;
    logic                    flags_ready;
    fpe_div_req_t            div_req;
    fpe_div_res_t            div_res;

    logic [DATA_W-1:0]       n_sat;
    logic [DATA_W:0]         sum_wide;
    logic                    out_free;

    fpe_flag_store #(
        .MAX_N (MAX_N)
    ) u_flag_store (
        .aclk    (aclk),
        .aresetn (aresetn),
        .rd_req  (rd_req),
        .rd_flag (rd_flag),
        .ready   (flags_ready)
    );

    fpe_serial_div u_serial_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (div_req),
        .res     (div_res)
    );

    // Arguments above the flag store's range are clamped to its top entry.
    always_comb begin
        if (int'(s_tdata) > MAX_N) begin
            n_sat = DATA_W'(MAX_N);
        end else begin
            n_sat = s_tdata;
        end
    end

    // The output register may be loaded when it is empty or being emptied.
    assign out_free = !m_tvalid_reg || m_tready;
    assign sum_wide = {1'b0, sum_reg} + {1'b0, div_res.quotient};

    always_comb begin
        state_next       = state_reg;
        n_next           = n_reg;
        p_next           = p_reg;
        q_next           = q_reg;
        sum_next         = sum_reg;
        pend_prime_next  = pend_prime_reg;
        pend_exp_next    = pend_exp_reg;
        pend_last_next   = pend_last_reg;
        pend_empty_next  = pend_empty_reg;
        have_pend_next   = have_pend_reg;
        m_tvalid_next    = m_tvalid_reg && !m_tready;
        m_tdata_next     = m_tdata_reg;
        m_tlast_next     = m_tlast_reg;
        m_tuser_next     = m_tuser_reg;
        rd_req.en        = 1'b0;
        rd_req.addr      = p_reg;
        div_req.start    = 1'b0;
        div_req.dividend = q_reg;
        div_req.divisor  = p_reg;
        unique case (state_reg)
            ST_SIEVE: begin
                if (flags_ready) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (s_tvalid) begin
                    n_next = n_sat;
                    if (n_sat < FIRST_PRIME) begin
                        // No prime factors: a single flagged result.
                        pend_prime_next = '0;
                        pend_exp_next   = '0;
                        pend_last_next  = 1'b1;
                        pend_empty_next = 1'b1;
                        state_next      = ST_EMIT;
                    end else begin
                        p_next         = FIRST_PRIME;
                        have_pend_next = 1'b0;
                        state_next     = ST_READ;
                    end
                end
            end
            ST_READ: begin
                rd_req.en  = 1'b1;
                state_next = ST_CHECK;
            end
            ST_CHECK: begin
                if (rd_flag) begin
                    q_next   = n_reg;
                    sum_next = '0;
                    // A held result is now known not to be the last one.
                    state_next = have_pend_reg ? ST_EMIT : ST_DIV;
                end else if (p_reg == n_reg) begin
                    pend_last_next = 1'b1;
                    state_next     = ST_EMIT;
                end else begin
                    p_next     = p_reg + DATA_W'(1);
                    state_next = ST_READ;
                end
            end
            ST_DIV: begin
                if (q_reg >= p_reg) begin
                    div_req.start = 1'b1;
                    state_next    = ST_DIV_WAIT;
                end else begin
                    pend_prime_next = p_reg;
                    pend_exp_next   = sum_reg;
                    pend_empty_next = 1'b0;
                    have_pend_next  = 1'b1;
                    if (p_reg == n_reg) begin
                        pend_last_next = 1'b1;
                        state_next     = ST_EMIT;
                    end else begin
                        pend_last_next = 1'b0;
                        p_next         = p_reg + DATA_W'(1);
                        state_next     = ST_READ;
                    end
                end
            end
            ST_DIV_WAIT: begin
                if (div_res.done) begin
                    q_next = div_res.quotient;
                    if (sum_wide[DATA_W]) begin
                        sum_next = '1;
                    end else begin
                        sum_next = sum_wide[DATA_W-1:0];
                    end
                    state_next = ST_DIV;
                end
            end
            ST_EMIT: begin
                if (out_free) begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = {pend_exp_reg, pend_prime_reg};
                    m_tlast_next  = pend_last_reg;
                    m_tuser_next  = pend_empty_reg;
                    state_next    = pend_last_reg ? ST_IDLE : ST_DIV;
                end
            end
            default: state_next = ST_SIEVE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_SIEVE;
            have_pend_reg <= 1'b0;
            m_tvalid_reg  <= 1'b0;
        end else begin
            state_reg     <= state_next;
            have_pend_reg <= have_pend_next;
            m_tvalid_reg  <= m_tvalid_next;
        end
        n_reg          <= n_next;
        p_reg          <= p_next;
        q_reg          <= q_next;
        sum_reg        <= sum_next;
        pend_prime_reg <= pend_prime_next;
        pend_exp_reg   <= pend_exp_next;
        pend_last_reg  <= pend_last_next;
        pend_empty_reg <= pend_empty_next;
        m_tdata_reg    <= m_tdata_next;
        m_tlast_reg    <= m_tlast_next;
        m_tuser_reg    <= m_tuser_next;
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tlast  = m_tlast_reg;
    assign m_tuser  = m_tuser_reg;

endmodule

@@ rtl/core/fpe_serial_div.sv @@
module fpe_serial_div import fpe_pkg::*; (
    input  logic         aclk,
    input  logic         aresetn,
    input  fpe_div_req_t req,
    output fpe_div_res_t res
);

    localparam int CNT_W = $clog2(DATA_W);

    logic               busy_reg;
    logic               done_reg;
    logic [CNT_W-1:0]   cnt_reg;
    logic [DATA_W-1:0]  dvd_reg;
    logic [DATA_W-1:0]  rem_reg;
    logic [DATA_W-1:0]  dvs_reg;

    logic [DATA_W:0]    rem_sh;
    logic               take;
    logic [DATA_W:0]    rem_diff;
    logic [DATA_W-1:0]  rem_next;
    logic [DATA_W-1:0]  dvd_next;

    // Restoring division, one quotient bit per cycle. The dividend shifts out
    // at the top while the quotient bits shift in at the bottom.
    always_comb begin
        rem_sh   = {rem_reg, dvd_reg[DATA_W-1]};
        take     = (rem_sh >= {1'b0, dvs_reg});
        rem_diff = rem_sh - {1'b0, dvs_reg};
        rem_next = take ? rem_diff[DATA_W-1:0] : rem_sh[DATA_W-1:0];
        dvd_next = {dvd_reg[DATA_W-2:0], take};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (req.start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
                dvd_reg  <= req.dividend;
                dvs_reg  <= req.divisor;
                rem_reg  <= '0;
            end else if (busy_reg) begin
                dvd_reg <= dvd_next;
                rem_reg <= rem_next;
                cnt_reg <= cnt_reg + CNT_W'(1);
                if (cnt_reg == CNT_W'(DATA_W - 1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign res.done     = done_reg;
    assign res.quotient = dvd_reg;

endmodule

@@ rtl/core/fpe_flag_store.sv @@
module fpe_flag_store import fpe_pkg::*; #(
    parameter int MAX_N = MAX_N_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  fpe_rd_req_t rd_req,
    output logic        rd_flag,
    output logic        ready
);

    localparam int FLAG_DEPTH = MAX_N + 1;
    localparam int FLAG_AW    = $clog2(FLAG_DEPTH);
    localparam int IDX_W      = FLAG_AW + 1;

    typedef enum logic [2:0] {
        SV_FILL,
        SV_OUTER_RD,
        SV_OUTER_CHK,
        SV_MARK,
        SV_DONE
    } sv_state_t;

    logic flag_mem [FLAG_DEPTH];

    sv_state_t         state_reg, state_next;
    logic [IDX_W-1:0]  idx_reg, idx_next;
    logic [IDX_W-1:0]  base_reg, base_next;
    logic [IDX_W-1:0]  sq_reg, sq_next;
    logic              rd_flag_reg;

    logic               wr_en;
    logic [FLAG_AW-1:0] wr_addr;
    logic               wr_data;
    logic               rd_en;
    logic [FLAG_AW-1:0] rd_addr;

    // Fill every entry with "prime" except 0 and 1, then strike out the
    // multiples of each prime base from its square upwards. The square of the
    // next base is kept by adding 2*base + 1.
    always_comb begin
        state_next = state_reg;
        idx_next   = idx_reg;
        base_next  = base_reg;
        sq_next    = sq_reg;
        wr_en      = 1'b0;
        wr_addr    = idx_reg[FLAG_AW-1:0];
        wr_data    = 1'b0;
        rd_en      = 1'b0;
        rd_addr    = base_reg[FLAG_AW-1:0];
        unique case (state_reg)
            SV_FILL: begin
                wr_en   = 1'b1;
                wr_data = (idx_reg >= IDX_W'(2));
                if (idx_reg == IDX_W'(MAX_N)) begin
                    state_next = SV_OUTER_RD;
                    base_next  = IDX_W'(2);
                    sq_next    = IDX_W'(4);
                end else begin
                    idx_next = idx_reg + IDX_W'(1);
                end
            end
            SV_OUTER_RD: begin
                if (sq_reg > IDX_W'(MAX_N)) begin
                    state_next = SV_DONE;
                end else begin
                    rd_en      = 1'b1;
                    state_next = SV_OUTER_CHK;
                end
            end
            SV_OUTER_CHK: begin
                if (rd_flag_reg) begin
                    idx_next   = sq_reg;
                    state_next = SV_MARK;
                end else begin
                    base_next  = base_reg + IDX_W'(1);
                    sq_next    = sq_reg + {base_reg[IDX_W-2:0], 1'b1};
                    state_next = SV_OUTER_RD;
                end
            end
            SV_MARK: begin
                if (idx_reg > IDX_W'(MAX_N)) begin
                    base_next  = base_reg + IDX_W'(1);
                    sq_next    = sq_reg + {base_reg[IDX_W-2:0], 1'b1};
                    state_next = SV_OUTER_RD;
                end else begin
                    wr_en    = 1'b1;
                    idx_next = idx_reg + base_reg;
                end
            end
            SV_DONE: begin
                rd_en   = rd_req.en;
                rd_addr = FLAG_AW'(rd_req.addr);
            end
            default: state_next = SV_FILL;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= SV_FILL;
            idx_reg   <= '0;
            base_reg  <= '0;
            sq_reg    <= '0;
        end else begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
            base_reg  <= base_next;
            sq_reg    <= sq_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            flag_mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_flag_reg <= flag_mem[rd_addr];
        end
    end

    assign rd_flag = rd_flag_reg;
    assign ready   = (state_reg == SV_DONE);

endmodule

@@ rtl/core/fpe_checker.sv @@
module fpe_checker import fpe_pkg::*; (
    input logic                  aclk,
    input logic                  aresetn,
    input logic                  s_tvalid,
    input logic                  s_tready,
    input logic [DATA_W-1:0]     s_tdata,
    input logic                  m_tvalid,
    input logic                  m_tready,
    input logic [OUT_DATA_W-1:0] m_tdata,
    input logic                  m_tlast,
    input logic                  m_tuser
);

    // A stalled result transaction keeps its contents.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast)
            && $stable(m_tuser))
        else $error("result changed while stalled");

    // The empty result is a lone, zeroed, closing transaction.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser |-> m_tlast && (m_tdata == '0))
        else $error("empty result malformed");

    // A real result names a prime of at least two with a non-zero exponent.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser |-> (m_tdata[DATA_W-1:0] >= FIRST_PRIME)
            && (m_tdata[OUT_DATA_W-1:DATA_W] != '0))
        else $error("result prime or exponent out of range");

    // Reset leaves no result pending and the input closed while the sieve runs.
    assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid && !s_tready)
        else $error("outputs active straight after reset");

    // No new argument is taken while a result transaction that is not the last is offered.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tlast |-> !(s_tvalid && s_tready))
        else $error("argument accepted in the middle of a run");

endmodule

bind factorial_prime_exponents fpe_checker u_fpe_checker (.*);
